FILE: hdl/qpe_pkg.sv
// ============================================================================
// QOI pixel encoder package
// Shared types and constants for the pixel encoder front end, the token
// queue and the byte serializer.
// ============================================================================
`default_nettype none

package qpe_pkg;

    // Default sizes of the color table and of the longest run.
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_RUN_DEF       = 62;

    // Token queue between the front end and the byte serializer.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One pixel causes at most six stream bytes.
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Configuration port.
    localparam int               CFG_IDX_W        = 8;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWOS_FIELDS  = 8'd1;

    // Code tags of the stream.
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;
    localparam logic [7:0] TAG_RGB   = 8'hFE;
    localparam logic [7:0] TAG_RGBA  = 8'hFF;

    // Hash sum width and reciprocal shift for the table index.
    localparam int SUM_W       = 13;
    localparam int RECIP_SHIFT = 20;

    typedef struct packed {
        logic alpha_enable;
        logic twos_complement_fields;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       end_of_image;
    } t_pixel;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_token_push;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  empty;
    } t_fifo_status;

endpackage

`default_nettype wire

FILE: hdl/qpe_front.sv
// ============================================================================
// QOI pixel encoder front end
// Four-stage pipeline: hash sum, reciprocal quotient, table index and table
// read, then the code decision with state update. Emits one byte token per
// pixel that causes any bytes.
// ============================================================================
`default_nettype none

module qpe_front #(
    parameter int TABLE_ENTRIES = qpe_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_RUN       = qpe_pkg::MAX_RUN_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  qpe_pkg::t_pixel      i_pixel,
    input  qpe_pkg::t_cfg        i_cfg,
    output qpe_pkg::t_token_push o_push,
    output logic [2:0]           o_inflight
);
    import qpe_pkg::*;

    localparam int HW       = $clog2(TABLE_ENTRIES);
    localparam int RECIP    = (2 ** RECIP_SHIFT + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
    localparam int PROD_W   = SUM_W + RECIP_SHIFT + 1;
    localparam logic [5:0] RUN_LIMIT = 6'(MAX_RUN - 1);

    // Pipeline registers.
    logic             r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_pixel           r_a_pix, r_b_pix, r_c_pix, r_d_pix;
    logic [SUM_W-1:0] r_a_sum, r_b_sum;
    logic [SUM_W-1:0] r_b_q;
    logic [HW-1:0]    r_c_h;
    logic [HW-1:0]    r_d_h;

    // Table storage, valid bits and write forwarding.
    logic [31:0]      r_mem [TABLE_ENTRIES];
    logic [31:0]      r_mem_q;
    logic [TABLE_ENTRIES-1:0] r_tbl_vld;
    logic             r_fwd;
    logic [31:0]      r_fwd_data;

    // Encoder state.
    logic [31:0] r_prev, n_prev;
    logic        r_run_act, n_run_act;
    logic [5:0]  r_run_cnt, n_run_cnt;

    logic [SUM_W-1:0]  c_sum;
    logic [PROD_W-1:0] c_prod;
    logic [SUM_W-1:0]  c_qn;
    logic [SUM_W-1:0]  c_rem;
    logic [HW-1:0]     c_h;

    // Hash sum of the incoming pixel.
    always_comb begin
        c_sum = SUM_W'(i_pixel.red) * SUM_W'(3) + SUM_W'(i_pixel.green) * SUM_W'(5)
              + SUM_W'(i_pixel.blue) * SUM_W'(7);
        if (i_cfg.alpha_enable) begin
            c_sum = c_sum + SUM_W'(i_pixel.alpha) * SUM_W'(11);
        end
    end

    // Quotient by multiplication with the reciprocal, exact over the sum range.
    assign c_prod = PROD_W'(r_a_sum) * PROD_W'(RECIP);

    // Remainder gives the table index.
    assign c_qn  = SUM_W'(r_b_q * SUM_W'(TABLE_ENTRIES));
    assign c_rem = r_b_sum - c_qn;
    assign c_h   = c_rem[HW-1:0];

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_a_pix <= i_pixel;
        r_a_sum <= c_sum;
        r_b_pix <= r_a_pix;
        r_b_sum <= r_a_sum;
        r_b_q   <= c_prod[RECIP_SHIFT +: SUM_W];
        r_c_pix <= r_b_pix;
        r_c_h   <= c_h;
        r_d_pix <= r_c_pix;
        r_d_h   <= r_c_h;
    end

    // Decision stage.
    logic [7:0]  pr, pg, pb, pa;
    logic [31:0] color;
    logic [31:0] td;
    logic        same, alpha_same, tbl_hit, diff_ok, luma_ok;
    logic signed [8:0] dr, dg, db;
    logic signed [9:0] cr, cb;
    logic        wr, clr;
    logic [31:0] wdata;
    logic [CNT_W-1:0] n;
    t_token      tok;
    logic [5:0]  cnt1;
    logic [1:0]  fr2, fg2, fb2;
    logic [5:0]  lg;
    logic [3:0]  lr, lb;

    always_comb begin
        pr = r_prev[7:0];
        pg = r_prev[15:8];
        pb = r_prev[23:16];
        pa = r_prev[31:24];
        color = {r_d_pix.alpha, r_d_pix.blue, r_d_pix.green, r_d_pix.red};
        // An entry not written since reset or the last pixel reads as zero.
        td = !r_tbl_vld[r_d_h] ? '0 : (r_fwd ? r_fwd_data : r_mem_q);
        same = i_cfg.alpha_enable ? (color == r_prev) : (color[23:0] == r_prev[23:0]);
        alpha_same = !i_cfg.alpha_enable || (r_d_pix.alpha == pa);
        dr = $signed({1'b0, r_d_pix.red})   - $signed({1'b0, pr});
        dg = $signed({1'b0, r_d_pix.green}) - $signed({1'b0, pg});
        db = $signed({1'b0, r_d_pix.blue})  - $signed({1'b0, pb});
        cr = $signed({dr[8], dr}) - $signed({dg[8], dg});
        cb = $signed({db[8], db}) - $signed({dg[8], dg});
        tbl_hit = i_cfg.alpha_enable ? (td == color) : (td[23:0] == color[23:0]);
        diff_ok = alpha_same && dr >= -9'sd2 && dr <= 9'sd1 && dg >= -9'sd2 &&
                  dg <= 9'sd1 && db >= -9'sd2 && db <= 9'sd1;
        luma_ok = alpha_same && dg >= -9'sd32 && dg <= 9'sd31 && cr >= -10'sd8 &&
                  cr <= 10'sd7 && cb >= -10'sd8 && cb <= 10'sd7;
        // Biased fields flip the top bit of each two's complement field.
        fr2 = i_cfg.twos_complement_fields ? dr[1:0] : {~dr[1], dr[0]};
        fg2 = i_cfg.twos_complement_fields ? dg[1:0] : {~dg[1], dg[0]};
        fb2 = i_cfg.twos_complement_fields ? db[1:0] : {~db[1], db[0]};
        lg  = i_cfg.twos_complement_fields ? dg[5:0] : {~dg[5], dg[4:0]};
        lr  = i_cfg.twos_complement_fields ? cr[3:0] : {~cr[3], cr[2:0]};
        lb  = i_cfg.twos_complement_fields ? cb[3:0] : {~cb[3], cb[2:0]};
        cnt1 = r_run_cnt + 6'd1;

        tok = '0;
        n = '0;
        n_prev = r_prev;
        n_run_act = r_run_act;
        n_run_cnt = r_run_cnt;
        wr = 1'b0;
        clr = 1'b0;
        wdata = i_cfg.alpha_enable ? color : {8'hFF, color[23:0]};

        if (r_d_vld) begin
            if (same) begin
                if (!r_run_act) begin
                    n_run_act = 1'b1;
                    n_run_cnt = '0;
                end else begin
                    n_run_cnt = cnt1;
                    if (cnt1 == RUN_LIMIT) begin
                        tok.bytes[n] = {TAG_RUN, cnt1};
                        n = n + 1'b1;
                        n_run_act = 1'b0;
                    end
                end
            end else begin
                // A color change closes any open run first.
                if (r_run_act) begin
                    tok.bytes[n] = {TAG_RUN, r_run_cnt};
                    n = n + 1'b1;
                    n_run_act = 1'b0;
                end
                if (diff_ok) begin
                    tok.bytes[n] = {TAG_DIFF, fr2, fg2, fb2};
                    n = n + 1'b1;
                end else if (tbl_hit) begin
                    tok.bytes[n] = {TAG_INDEX, 6'(r_d_h)};
                    n = n + 1'b1;
                end else if (luma_ok) begin
                    tok.bytes[n] = {TAG_LUMA, lg};
                    n = n + 1'b1;
                    tok.bytes[n] = {lr, lb};
                    n = n + 1'b1;
                end else begin
                    tok.bytes[n] = alpha_same ? TAG_RGB : TAG_RGBA;
                    n = n + 1'b1;
                    tok.bytes[n] = r_d_pix.red;
                    n = n + 1'b1;
                    tok.bytes[n] = r_d_pix.green;
                    n = n + 1'b1;
                    tok.bytes[n] = r_d_pix.blue;
                    n = n + 1'b1;
                    if (!alpha_same) begin
                        tok.bytes[n] = r_d_pix.alpha;
                        n = n + 1'b1;
                    end
                    wr = 1'b1;
                end
                n_prev = color;
            end
            // The last pixel flushes an open run and clears the state.
            if (r_d_pix.end_of_image) begin
                if (n_run_act) begin
                    tok.bytes[n] = {TAG_RUN, n_run_cnt};
                    n = n + 1'b1;
                end
                clr = 1'b1;
            end
        end
        tok.count = n;
    end

    assign o_push.valid = r_d_vld && (n != '0);
    assign o_push.token = tok;
    assign o_inflight = {2'b00, r_a_vld} + {2'b00, r_b_vld} + {2'b00, r_c_vld}
                      + {2'b00, r_d_vld};

    // Control state and table valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_prev    <= '0;
            r_run_act <= 1'b0;
            r_run_cnt <= '0;
            r_tbl_vld <= '0;
            r_fwd     <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_fwd   <= wr && (r_d_h == r_c_h);
            if (clr) begin
                r_prev    <= '0;
                r_run_act <= 1'b0;
                r_run_cnt <= '0;
                r_tbl_vld <= '0;
            end else begin
                r_prev    <= n_prev;
                r_run_act <= n_run_act;
                r_run_cnt <= n_run_cnt;
                if (wr) begin
                    r_tbl_vld[r_d_h] <= 1'b1;
                end
            end
        end
    end

    // Color table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_d_h] <= wdata;
        end
        r_mem_q    <= r_mem[r_c_h];
        r_fwd_data <= wdata;
    end

endmodule

`default_nettype wire

FILE: hdl/qpe_token_fifo.sv
// ============================================================================
// QOI pixel encoder token queue
// Short queue of byte tokens between the front end and the serializer.
// ============================================================================
`default_nettype none

module qpe_token_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  qpe_pkg::t_token_push i_push,
    input  wire                  i_pop,
    output qpe_pkg::t_token      o_head,
    output qpe_pkg::t_fifo_status o_status
);
    import qpe_pkg::*;

    t_token                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push.valid) - FIFO_CNT_W'(do_pop);
        end
    end

    // Token storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.token;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/qpe_back.sv
// ============================================================================
// QOI pixel encoder byte serializer
// Takes tokens from the queue and hands out their bytes one at a time.
// ============================================================================
`default_nettype none

module qpe_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  qpe_pkg::t_token       i_head,
    input  qpe_pkg::t_fifo_status i_status,
    output logic                  o_fifo_pop,
    output logic                  o_empty,
    input  wire                   i_pop,
    output logic [7:0]            o_code_byte,
    output logic                  o_last_of_item
);
    import qpe_pkg::*;

    t_token           r_cur;
    logic [CNT_W-1:0] r_idx;
    logic             r_busy;
    logic             last, take, load;

    assign last = (r_idx == r_cur.count - 1'b1);
    assign take = r_busy && i_pop;
    assign load = !i_status.empty && (!r_busy || (take && last));

    assign o_fifo_pop     = load;
    assign o_empty        = !r_busy;
    assign o_code_byte    = r_cur.bytes[r_idx];
    assign o_last_of_item = last;

    // Byte index and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Current token.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_head;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/qoi_pixel_encoder_unit.sv
// ============================================================================
// QOI pixel encoder
// Codes one pixel per item into QOI-style stream bytes.
// ============================================================================
// A pixel is accepted in every cycle in which full is low; full rises only
// when the token queue plus the four pipeline stages could not hold another
// pixel. Each pixel causes zero to six bytes and the serializer hands out
// one byte per cycle while i_pop is high; pixels that extend a run cause no
// byte short of the run limit, so the sustained rate is one pixel per cycle
// while the average code length stays at or below one byte. The color table
// needs no clearing pass after reset or after the last pixel of an image.
`default_nettype none

module qoi_pixel_encoder_unit #(
    parameter int TABLE_ENTRIES = qpe_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_RUN       = qpe_pkg::MAX_RUN_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    output logic                          o_full,
    input  wire  [7:0]                    i_red,
    input  wire  [7:0]                    i_green,
    input  wire  [7:0]                    i_blue,
    input  wire  [7:0]                    i_alpha,
    input  wire                           i_end_of_image,
    output logic                          o_empty,
    input  wire                           i_pop,
    output logic [7:0]                    o_code_byte,
    output logic                          o_last_of_item,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [qpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire                           i_cfg_data
);
    import qpe_pkg::*;

    t_cfg         r_cfg;
    t_pixel       pixel;
    t_token_push  push;
    t_token       head;
    t_fifo_status status;
    logic [2:0]   inflight;
    logic         fifo_pop;
    logic [FIFO_CNT_W:0] occupancy;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ALPHA_ENABLE: r_cfg.alpha_enable <= i_cfg_data;
                REG_TWOS_FIELDS:  r_cfg.twos_complement_fields <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input is held off while queued and in-flight tokens could fill the queue.
    assign occupancy = {1'b0, status.count} + (FIFO_CNT_W + 1)'(inflight);
    assign o_full    = (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));

    assign pixel = '{red: i_red, green: i_green, blue: i_blue, alpha: i_alpha,
                     end_of_image: i_end_of_image};

    qpe_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_RUN       (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_push && !o_full),
        .i_pixel    (pixel),
        .i_cfg      (r_cfg),
        .o_push     (push),
        .o_inflight (inflight)
    );

    qpe_token_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (fifo_pop),
        .o_head   (head),
        .o_status (status)
    );

    qpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_status       (status),
        .o_fifo_pop     (fifo_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_code_byte    (o_code_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

`default_nettype wire

FILE: hdl/qpe_checker.sv
// ============================================================================
// QOI pixel encoder port checker
// Watches the top-level ports for queue behavior and item accounting.
// ============================================================================
`default_nettype none

module qpe_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_push,
    input wire       o_full,
    input wire       o_empty,
    input wire       i_pop,
    input wire [7:0] o_code_byte,
    input wire       o_last_of_item,
    input wire       i_cfg_valid,
    input wire       o_cfg_ready
);
    // Accepted items less the items whose last byte has been taken.
    logic [31:0] r_open;
    logic        acc, done;

    assign acc  = i_push && !o_full;
    assign done = i_pop && !o_empty && o_last_of_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + 32'(acc) - 32'(done);
        end
    end

    // After reset the block shows no result and takes items.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("block not idle after reset");

    // A waiting byte holds while it is not taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_code_byte) &&
                                  $stable(o_last_of_item)))
        else $error("waiting byte changed");

    // No item ends without having been accepted.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_open != 32'd0))
        else $error("item finished that was never accepted");

    // A configuration write is taken while the block is idle.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_empty && r_open == 32'd0) |-> o_cfg_ready)
        else $error("configuration write refused while idle");

endmodule

bind qoi_pixel_encoder_unit qpe_checker u_qpe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_push         (i_push),
    .o_full         (o_full),
    .o_empty        (o_empty),
    .i_pop          (i_pop),
    .o_code_byte    (o_code_byte),
    .o_last_of_item (o_last_of_item),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);

`default_nettype wire
